// ----- rtl/core/rmsn_pkg.sv -----
// ----------------------------------------------------------------------------
// rmsn_pkg
// Shared widths, register indexes and controller states for the RMS
// normalization unit.
// ----------------------------------------------------------------------------
package rmsn_pkg;

   localparam int unsigned DATA_W    = 16;   // Q4.12 element width
   localparam int unsigned COUNT_W   = 7;    // element count and length width
   localparam int unsigned SUM_W     = 48;   // sum of squares width
   localparam int unsigned EPS_W     = 32;   // epsilon, unsigned Q8.24
   localparam int unsigned MEAN_W    = 34;   // mean square plus epsilon
   localparam int unsigned RAD_W     = 57;   // radicand of the square root
   localparam int unsigned ROOT_W    = 29;   // square root result
   localparam int unsigned ROOT_STEPS = 29;
   localparam int unsigned MAG_W     = 31;   // magnitude of x * w
   localparam int unsigned NUM_W     = 43;   // scaled numerator
   localparam int unsigned QUO_W     = 16;   // output quotient bits
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned CSR_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON       = 8'd1;

   localparam logic [COUNT_W-1:0] VLEN_RESET = 7'd64;
   localparam logic [EPS_W-1:0]   EPS_RESET  = 32'd16;

   typedef enum logic [6:0] {
      ST_LOAD  = 7'b0000001,
      ST_MEAN  = 7'b0000010,
      ST_ROOT  = 7'b0000100,
      ST_READ  = 7'b0001000,
      ST_MULT  = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_QUOT  = 7'b1000000
   } state_type;

endpackage

// ----- rtl/core/rms_normalize_vector_unit.sv -----
// ----------------------------------------------------------------------------
// rms_normalize_vector_unit
// RMS normalization of a vector of Q4.12 activations with per-element weights.
//
//   channel | direction | word
//   --------+-----------+------------------------------------------------------
//   req_    | in        | tdata[15:0] x_value, tdata[31:16] weight_value
//   rsp_    | out       | tdata[15:0] y_value, tlast = last element of vector
//   csr_    | in        | index 0 vector_length[6:0], index 1 epsilon[31:0]
//
// Loading takes one word per cycle while the unit is in its load state.
// The word that completes a vector starts a restoring divide for the
// mean square and a bitwise square root; each result then passes through
// a store read, a multiply, a setup step, 16 quotient steps of the
// per-element divider and a hand-off of the word to the output register.
// The output register lets the next element compute while a result waits.
// Reset clears the controller, sum, count and configuration registers; the
// store is not cleared since every entry is written before it is read.
// ----------------------------------------------------------------------------
module rms_normalize_vector_unit
   import rmsn_pkg::*;
#(
   parameter int unsigned MAX_VECTOR_LENGTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   // Input stream.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [15:0] x_value, [31:16] weight_value
   // Result stream.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [15:0] y_value
   output logic                 rsp_tlast,   // last_result
   // Register write port.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int unsigned ADDR_W = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
   localparam logic [COUNT_W-1:0] LEN_MAX = COUNT_W'(MAX_VECTOR_LENGTH);

   // ------------------------------------------------------------------------
   // Configuration registers. Writes are always taken; unknown indexes drop.
   // ------------------------------------------------------------------------
   logic [COUNT_W-1:0] vlen_ff;
   logic [EPS_W-1:0]   eps_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= VLEN_RESET;
         eps_ff  <= EPS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VECTOR_LENGTH: vlen_ff <= csr_data[COUNT_W-1:0];
            CSR_EPSILON:       eps_ff  <= csr_data[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Controller and datapath registers.
   // ------------------------------------------------------------------------
   state_type           state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  n_ff, n_in;            // elements in the vector being emitted
   logic [COUNT_W-1:0]  elem_ff, elem_in;      // element being emitted
   logic [5:0]          step_ff, step_in;      // iteration counter of mean, root, quotient

   // Mean square divider.
   logic [COUNT_W-1:0]  mrem_ff, mrem_in;
   logic [SUM_W-1:0]    mquo_ff, mquo_in;
   // Square root.
   logic [RAD_W-1:0]    rv_ff, rv_in;
   logic [RAD_W-1:0]    rres_ff, rres_in;
   logic [RAD_W-1:0]    rbit_ff, rbit_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   // Per-element scaling.
   logic signed [31:0]  prod_ff, prod_in;
   logic                neg_ff, neg_in;
   logic                zero_ff, zero_in;
   logic                sat_ff, sat_in;
   logic [NUM_W-1:0]    qrem_ff, qrem_in;
   logic [NUM_W:0]      qdvs_ff, qdvs_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   // Output register.
   logic                out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]   out_y_ff, out_y_in;
   logic                out_last_ff, out_last_in;

   // Store: one word per element, {weight, x}, read data registered.
   logic [2*DATA_W-1:0] store_mem [MAX_VECTOR_LENGTH];
   logic [2*DATA_W-1:0] rd_data_ff;

   // ------------------------------------------------------------------------
   // Combinational helpers.
   // ------------------------------------------------------------------------
   logic                req_take;
   logic                out_free;
   logic signed [DATA_W-1:0] in_x, in_w, rd_x, rd_w;
   logic signed [31:0]  square;
   logic [SUM_W-1:0]    sum_next;
   logic [COUNT_W-1:0]  count_next;
   logic [COUNT_W-1:0]  len_eff;
   logic [COUNT_W:0]    mtrial;
   logic                mge;
   logic [MEAN_W-1:0]   mean;
   logic [RAD_W:0]      rtrial;
   logic                rge;
   logic [MAG_W-1:0]    mag;
   logic [NUM_W-1:0]    numer;
   logic                qge;
   logic [QUO_W-1:0]    lim;
   logic [QUO_W-1:0]    qsel;
   logic                last_elem;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign in_x = req_tdata[DATA_W-1:0];
   assign in_w = req_tdata[2*DATA_W-1:DATA_W];
   assign rd_x = rd_data_ff[DATA_W-1:0];
   assign rd_w = rd_data_ff[2*DATA_W-1:DATA_W];

   always_ff @(posedge clock) begin
      if (req_take) begin
         store_mem[count_ff[ADDR_W-1:0]] <= req_tdata;
      end
      rd_data_ff <= store_mem[elem_ff[ADDR_W-1:0]];
   end

   always_comb begin
      square     = in_x * in_x;
      sum_next   = sum_ff + SUM_W'(unsigned'(square));
      count_next = count_ff + 1'b1;
      // A length of zero acts as one; lengths above the store depth clamp.
      if (vlen_ff == '0) begin
         len_eff = COUNT_W'(1);
      end else if (vlen_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = vlen_ff;
      end

      // One quotient bit of sum / n per cycle.
      mtrial = {mrem_ff, mquo_ff[SUM_W-1]};
      mge    = (mtrial >= {1'b0, n_ff});
      // The mean of Q8.24 squares stays below 2^31, so 33 bits carry it.
      mean   = MEAN_W'({mquo_ff[SUM_W-2:0], mge}) + MEAN_W'(eps_ff);

      // Bitwise integer square root; res and bit never overlap, so the sum is an or.
      rtrial = {1'b0, rres_ff} + {1'b0, rbit_ff};
      rge    = ({1'b0, rv_ff} >= rtrial);

      // Magnitude and rounded numerator of (x * w * 2^12) / s.
      mag   = prod_ff[31] ? MAG_W'(-prod_ff) : MAG_W'(prod_ff);
      numer = {mag, 12'b0} + NUM_W'(root_ff[ROOT_W-1:1]);

      qge = ({1'b0, qrem_ff} >= qdvs_ff);

      lim  = neg_ff ? 16'h8000 : 16'h7FFF;
      qsel = (sat_ff || (quo_ff > lim)) ? lim : quo_ff;
      last_elem = ((elem_ff + 1'b1) == n_ff);
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      elem_in      = elem_ff;
      step_in      = step_ff;
      mrem_in      = mrem_ff;
      mquo_in      = mquo_ff;
      rv_in        = rv_ff;
      rres_in      = rres_ff;
      rbit_in      = rbit_ff;
      root_in      = root_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      sat_in       = sat_ff;
      qrem_in      = qrem_ff;
      qdvs_in      = qdvs_ff;
      quo_in       = quo_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               sum_in   = sum_next;
               count_in = count_next;
               if (count_next >= len_eff) begin
                  // Vector complete: hand the sum to the divider, clear for the next.
                  sum_in   = '0;
                  count_in = '0;
                  n_in     = count_next;
                  mrem_in  = '0;
                  mquo_in  = sum_next;
                  step_in  = '0;
                  state_in = ST_MEAN;
               end
            end
         end
         ST_MEAN: begin
            mrem_in = mge ? COUNT_W'(mtrial - {1'b0, n_ff}) : mtrial[COUNT_W-1:0];
            mquo_in = {mquo_ff[SUM_W-2:0], mge};
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(SUM_W - 1)) begin
               rv_in    = {mean[32:0], 24'b0};
               rres_in  = '0;
               rbit_in  = {1'b1, {(RAD_W-1){1'b0}}};
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rge) begin
               rv_in   = RAD_W'({1'b0, rv_ff} - rtrial);
               rres_in = (rres_ff >> 1) + rbit_ff;
            end else begin
               rres_in = rres_ff >> 1;
            end
            rbit_in = rbit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == 6'(ROOT_STEPS - 1)) begin
               root_in  = rres_in[ROOT_W-1:0];
               elem_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // The store address follows elem_ff; data lands in rd_data_ff.
            state_in = ST_MULT;
         end
         ST_MULT: begin
            prod_in  = rd_x * rd_w;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            neg_in  = prod_ff[31];
            zero_in = (prod_ff == '0);
            // A quotient of 2^16 or more saturates; a zero root always lands here.
            sat_in  = ({2'b0, numer} >= {root_ff, 16'b0});
            qrem_in = numer;
            qdvs_in = {root_ff, 15'b0};
            quo_in  = '0;
            step_in = '0;
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            if (step_ff < 6'(QUO_W)) begin
               if (qge) begin
                  qrem_in = NUM_W'({1'b0, qrem_ff} - qdvs_ff);
               end
               quo_in  = {quo_ff[QUO_W-2:0], qge};
               qdvs_in = qdvs_ff >> 1;
               step_in = step_ff + 1'b1;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_y_in     = zero_ff ? '0 : (neg_ff ? DATA_W'(-qsel) : qsel);
               out_last_in  = last_elem;
               if (last_elem) begin
                  state_in = ST_LOAD;
               end else begin
                  elem_in  = elem_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         sum_ff       <= '0;
         count_ff     <= '0;
         n_ff         <= '0;
         elem_ff      <= '0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         elem_ff      <= elem_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mrem_ff     <= mrem_in;
      mquo_ff     <= mquo_in;
      rv_ff       <= rv_in;
      rres_ff     <= rres_in;
      rbit_ff     <= rbit_in;
      root_ff     <= root_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      sat_ff      <= sat_in;
      qrem_ff     <= qrem_in;
      qdvs_ff     <= qdvs_in;
      quo_ff      <= quo_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_y_ff;
   assign rsp_tlast  = out_last_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff < LEN_MAX || count_ff == LEN_MAX)
      else $error("element count passed the store depth");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_MULT || state_ff == ST_SCALE
       || state_ff == ST_QUOT) |-> (elem_ff < n_ff))
      else $error("emit index beyond vector length");

   a_mean_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MEAN && $past(state_ff) == ST_LOAD)
      |-> $past(req_tvalid && req_tready))
      else $error("mean divide started without a completing word");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUOT && out_free && last_elem && step_ff == 6'(QUO_W))
      |=> (sum_ff == '0 && count_ff == '0 && state_ff == ST_LOAD))
      else $error("sum or count not clear after the last result");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rms_normalize_vector_unit. Activation and weight
// words are streamed in, and every normalized element that comes back is
// compared with a bit-exact prediction kept in the bench. Random stalls
// on both streams, a long output hold-off and several register settings are
// exercised.
// ----------------------------------------------------------------------------
module testbench
   import rmsn_pkg::*;
();

   // Register indexes that the unit does not decode; writes to them must
   // leave both registers unchanged.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HIGH = 8'hFF;

   localparam int ITEM_TARGET   = 370;   // input words to send in total
   localparam int TAIL_ITEMS    = 60;    // final words sent without idling
   localparam int SETTLE_CYCLES = 40;    // quiet time before a register write
   localparam int HOLD_OFF      = 300;   // long output stall of the pressure test
   localparam int STALL_LIMIT   = 4000;  // cycles without any handshake

   typedef struct packed {
      logic [15:0] y_value;
      logic        last_result;
   } norm_element_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata = '0;   // [15:0] x_value, [31:16] weight_value
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;        // [15:0] y_value
   logic                 rsp_tlast;        // last_result
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   // Predicted state of the unit, mirrored word by word as it is accepted.
   logic [COUNT_W-1:0]   vlen_setting = VLEN_RESET;
   logic [EPS_W-1:0]     eps_setting = EPS_RESET;
   logic [15:0]          activations [64];
   logic [15:0]          weights [64];
   logic [SUM_W-1:0]     square_total = '0;
   logic [COUNT_W-1:0]   loaded_count = '0;

   // Normalized elements that the unit still owes us, oldest first.
   norm_element_type     awaited_elements [$];

   int                   failures = 0;
   int                   items_sent = 0;
   int                   hold_off_cycles = 0;   // set by a test, consumed by the receiver
   bit                   steady_tail = 1'b0;    // no idling on either side
   bit                   sender_bursty = 1'b1;

   rms_normalize_vector_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Largest r with r*r <= v, found one bit at a time. The radicand stays
   // below 2^57, so the root fits in 29 bits.
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 28; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= v) r = trial;
      end
      return r;
   endfunction

   // x * w / rms in Q4.12: the product is Q8.24, so it is shifted up by 12 and
   // divided by the Q.24 root, rounding half away from zero. A zero root
   // saturates any nonzero product toward its sign.
   function automatic logic [15:0] normalized_element(logic [15:0] x, logic [15:0] w,
                                                      longint unsigned root);
      longint          product;
      longint unsigned mag;
      longint unsigned limit;
      longint unsigned quotient;
      bit              negative;
      product  = longint'($signed(x)) * longint'($signed(w));
      negative = product < 0;
      mag      = negative ? longint'(-product) : longint'(product);
      limit    = negative ? 64'd32768 : 64'd32767;
      if (mag == 0) return 16'd0;
      if (root == 0) begin
         quotient = limit;
      end else begin
         quotient = ((mag << 12) + (root >> 1)) / root;
         if (quotient > limit) quotient = limit;
      end
      return negative ? 16'(-quotient) : 16'(quotient);
   endfunction

   // Takes one accepted word into the mirrored state. When it completes the
   // vector, every stored element is predicted and queued in order.
   task automatic absorb_element(logic [15:0] x, logic [15:0] w);
      longint           xs;
      longint unsigned  eff_len;
      longint unsigned  n;
      longint unsigned  mean_sq;
      longint unsigned  root;
      norm_element_type elem;
      xs = longint'($signed(x));
      activations[loaded_count[5:0]] = x;
      weights[loaded_count[5:0]]     = w;
      square_total = square_total + SUM_W'(xs * xs);
      loaded_count = loaded_count + 1'b1;

      // A length of zero behaves as one, and anything above the store depth
      // behaves as the full depth.
      eff_len = (vlen_setting == 0) ? 1 : (vlen_setting > 64) ? 64 : vlen_setting;
      if (loaded_count < eff_len) return;

      // If the length was lowered below the count mid-vector, the vector closes
      // here with every element received so far.
      n       = (loaded_count > 64) ? 64 : loaded_count;
      mean_sq = longint'(square_total) / n + eps_setting;
      root    = floor_sqrt(mean_sq << 24);
      for (int k = 0; k < n; k++) begin
         elem.y_value     = normalized_element(activations[k], weights[k], root);
         elem.last_result = (k == n - 1);
         awaited_elements.push_back(elem);
      end
      square_total = '0;
      loaded_count = '0;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Offers one word and waits for it to be taken; a random gap may come
   // first. The valid stays high on return so that back-to-back words never
   // lower and raise it within one step.
   task automatic send_word(logic [15:0] x, logic [15:0] w);
      if (!steady_tail && sender_bursty && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_element(x, w);
      items_sent++;
   endtask

   // One register write. The caller lowers csr_valid after its last write.
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_VECTOR_LENGTH: vlen_setting = value[COUNT_W-1:0];
         CSR_EPSILON:       eps_setting  = value;
         default:           ;
      endcase
   endtask

   // Stops offering words, waits for every owed element, then gives the unit
   // time to come back to its load state.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_elements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [CSR_DAT_W-1:0] length, logic [CSR_DAT_W-1:0] eps);
      drain_results();
      write_register(CSR_VECTOR_LENGTH, length);
      write_register(CSR_EPSILON, eps);
      csr_valid <= 1'b0;
   endtask

   // Random Q4.12 value: the two extremes, values near zero, values between
   // minus one and one, and the full range.
   function automatic logic [15:0] random_q412();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'($urandom_range(0, 8)) - 16'd4;
         3, 4:    return 16'($urandom_range(0, 8191)) - 16'd4096;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DAT_W-1:0] random_epsilon();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return EPS_RESET;
         2:       return $urandom_range(0, 255);
         3:       return $urandom_range(0, 1 << 20);
         4:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Starts from the reset settings (length 64, epsilon 16), so the first
   // three words cannot finish a vector. Lowering the length to two then
   // makes the next word close a vector of four elements.
   task automatic test_length_lowered_midway();
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h8000, 16'h7FFF);
      send_word(16'h0123, 16'h8000);
      drain_results();
      write_register(CSR_VECTOR_LENGTH, 32'd2);
      csr_valid <= 1'b0;
      send_word(16'hFFFF, 16'h0001);
   endtask

   // A length of zero acts as one, so every word is a vector of its own.
   // Writes to undecoded indexes must not disturb that.
   task automatic test_single_element_vectors();
      configure(32'd0, EPS_RESET);
      send_word(16'h8000, 16'h8000);
      send_word(16'h7FFF, 16'h8000);
      send_word(16'h0000, 16'h7FFF);
      drain_results();
      write_register(CSR_UNUSED_LOW, 32'd5);
      write_register(CSR_UNUSED_HIGH, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      send_word(16'h8000, 16'h7FFF);
   endtask

   // With epsilon zero and a sum of squares below the length, the mean
   // square and its root are zero: a zero product gives zero, any other
   // product saturates toward its sign.
   task automatic test_zero_root();
      configure(32'd2, 32'd0);
      send_word(16'h0000, 16'h0005);
      send_word(16'h0000, 16'hFFF9);
      send_word(16'h0001, 16'hFFFB);
      send_word(16'h0000, 16'h0003);
      send_word(16'hFFFF, 16'hFFF7);
      send_word(16'h0000, 16'h0000);
   endtask

   task automatic test_largest_epsilon();
      configure(32'd3, 32'hFFFF_FFFF);
      send_word(16'h7FFF, 16'h7FFF);
      send_word(16'h8000, 16'h8000);
      send_word(16'h0001, 16'hFFFF);
   endtask

   // The receiver stops for a long stretch while four short vectors are
   // offered, so the output register fills and the unit stops taking words.
   task automatic test_output_backpressure();
      configure(32'd4, EPS_RESET);
      hold_off_cycles = HOLD_OFF;
      repeat (16) send_word(random_q412(), random_q412());
      drain_results();
   endtask

   // Random settings and random vectors. The first phases pin the length
   // extremes; some phases lower the length part way through a vector.
   task automatic test_random_vectors();
      int phase;
      int length;
      int eff_len;
      int held;
      int shorter;
      int vectors;
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0:       length = 64;
            1:       length = 127;
            2:       length = 1;
            default: begin
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: length = $urandom_range(1, 8);
                  12, 13, 14: length = $urandom_range(9, 32);
                  15:         length = $urandom_range(33, 64);
                  16:         length = 0;
                  17:         length = $urandom_range(65, 127);
                  default:    length = $urandom_range(2, 4);
               endcase
            end
         endcase
         sender_bursty = $urandom_range(0, 2) != 0;
         configure(length, random_epsilon());
         eff_len = (length == 0) ? 1 : (length > 64) ? 64 : length;

         if (phase > 2 && eff_len >= 2 && $urandom_range(0, 4) == 0) begin
            // Part of a vector, then a length at or below what is already held.
            held = $urandom_range(1, eff_len - 1);
            repeat (held) send_word(random_q412(), random_q412());
            drain_results();
            shorter = $urandom_range(0, held);
            write_register(CSR_VECTOR_LENGTH, shorter);
            csr_valid <= 1'b0;
            send_word(random_q412(), random_q412());
            eff_len = (shorter == 0) ? 1 : shorter;
         end

         vectors = (eff_len > 16) ? 1 : $urandom_range(1, 3);
         repeat (vectors * eff_len) begin
            steady_tail = items_sent >= ITEM_TARGET - TAIL_ITEMS;
            send_word(random_q412(), random_q412());
         end
         phase++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Receiver: random stall bursts between stretches of steady readiness, and
   // the long hold-off when a test asks for it.
   initial begin : receiver
      @(posedge clock iff !reset);
      forever begin
         if (hold_off_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Every accepted result word is compared with the oldest owed element.
   always @(posedge clock) begin : result_checker
      norm_element_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_elements.size() == 0) begin
            $display("%0t: result with none owed, expected nothing, got y_value %0d last %0b",
                     $time, $signed(rsp_tdata), rsp_tlast);
            failures++;
         end else begin
            want = awaited_elements.pop_front();
            if (rsp_tdata !== want.y_value) begin
               $display("%0t: y_value mismatch, expected %0d, got %0d",
                        $time, $signed(want.y_value), $signed(rsp_tdata));
               failures++;
            end
            if (rsp_tlast !== want.last_result) begin
               $display("%0t: last_result mismatch, expected %0b, got %0b",
                        $time, want.last_result, rsp_tlast);
               failures++;
            end
         end
      end
   end

   // Ends the run if no word moves on any channel for too long.
   initial begin : watchdog
      int silent_cycles;
      silent_cycles = 0;
      while (silent_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            silent_cycles = 0;
         else
            silent_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Test sequence. Reset is held at the start and never asserted again.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_length_lowered_midway();
      test_single_element_vectors();
      test_zero_root();
      test_largest_epsilon();
      test_output_backpressure();
      test_random_vectors();
      // Waits for every owed element, then watches a while for strays.
      drain_results();
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/rmsn_pkg.sv
rtl/core/rms_normalize_vector_unit.sv
bench/testbench.sv
